// ===== rtl/core/ipv6_lpm_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv6 LPM package
// Shared types and codes for the stride-2 trie longest-prefix-match engine.
// ----------------------------------------------------------------------------
package ipv6_lpm_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam int ADDR_BITS = 128;
  localparam int LEVEL_BITS = 6;
  localparam logic [LEVEL_BITS-1:0] LAST_LEVEL = 6'd63;
  localparam logic [7:0] MAX_PLEN = 8'd128;

  typedef struct packed {
    logic        valid;
    logic [7:0]  plen;
    logic [31:0] as_num;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_LOAD,
    ST_WB,
    ST_PUT,
    ST_PWB,
    ST_CHK
  } lpm_state_t;

endpackage

// ===== rtl/core/ipv6_longest_prefix_match.sv =====
// ----------------------------------------------------------------------------
// IPv6 longest prefix match
// 4-ary trie, two address bits per level, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Usage: drive cmd, addr_high, addr_low, prefix_len, as_number and pulse
// start while busy is low; that edge accepts the transaction. busy stays high
// until the result. The result shows on match_found, matched_as and
// table_full, marked by done for exactly one cycle; the receiver cannot stall.
// Insert (cmd 0) walks or allocates nodes and writes the AS number at the
// level where the prefix ends; lookup (cmd 1) returns the deepest valid entry.
// One link-memory read per trie level sets the pace. A lookup passes through
// ST_STEP and ST_LOAD per level and ends in ST_STEP at a missing link or in
// ST_LOAD at the last level. An insert passes through ST_STEP and ST_LOAD per
// existing node or ST_WB per new node, then ST_PUT and ST_PWB or ST_CHK per
// target slot. done rises in the first cycle with busy low, so the next start
// can be accepted at the end of that cycle. One transaction at a time.
// Reset clears the root's links and sets the free pointer to node 1; node
// memories need no clearing since every node is written when it is allocated.
// ----------------------------------------------------------------------------
module ipv6_longest_prefix_match
  import ipv6_lpm_pkg::*;
#(
  parameter int NODE_COUNT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [63:0] addr_high,
  input  logic [63:0] addr_low,
  input  logic [7:0]  prefix_len,
  input  logic [31:0] as_number,
  output logic        done,
  output logic        match_found,
  output logic [31:0] matched_as,
  output logic        table_full
);

  localparam int NB = $clog2(NODE_COUNT);

  typedef logic [3:0][NB-1:0] row_t;

  row_t   lk_mem [NODE_COUNT];
  entry_t en_mem [NODE_COUNT];

  lpm_state_t state, state_next;

  logic [ADDR_BITS-1:0]  addr;
  logic [7:0]            plen;
  logic [31:0]           as_in;
  logic                  is_lookup;
  logic [LEVEL_BITS-1:0] lvl;
  logic [NB-1:0]         node;
  logic [NB-1:0]         newc;
  logic [NB:0]           next_free;
  row_t                  row;
  row_t                  root;
  row_t                  lk_rd;
  entry_t                en_rd;
  logic [1:0]            slot;
  logic [1:0]            last_slot;
  logic                  found;
  logic [31:0]           found_as;

  logic                  lk_we;
  logic [NB-1:0]         lk_waddr;
  row_t                  lk_wdata;
  logic [NB-1:0]         lk_raddr;
  logic                  en_we;
  logic [NB-1:0]         en_waddr;
  entry_t                en_wdata;
  logic [NB-1:0]         en_raddr;

  logic                  fin;
  logic                  fin_full;
  logic [1:0]            pr;
  logic [NB-1:0]         c_step;
  logic [NB-1:0]         c_put;
  logic [7:0]            base;
  logic                  end_odd;
  logic                  end_even;
  logic                  pool_full;
  logic                  found_now;
  logic [31:0]           as_now;
  logic                  replace_ok;

  assign busy      = (state != ST_IDLE);
  assign pr        = addr[ADDR_BITS-1 -: 2];
  assign c_step    = row[pr];
  assign c_put     = row[slot];
  assign base      = {1'b0, lvl, 1'b0};
  assign end_odd   = (plen <= base + 8'd1);
  assign end_even  = (plen <= base + 8'd2);
  assign pool_full = (next_free >= (NB+1)'(NODE_COUNT));
  assign replace_ok = !en_rd.valid || (en_rd.plen <= plen);
  assign found_now = found || (state == ST_LOAD && is_lookup && en_rd.valid);
  assign as_now    = (state == ST_LOAD && is_lookup && en_rd.valid) ? en_rd.as_num : found_as;

  always_comb begin
    state_next = state;
    lk_we      = 1'b0;
    lk_waddr   = next_free[NB-1:0];
    lk_wdata   = '0;
    lk_raddr   = c_step;
    en_we      = 1'b0;
    en_waddr   = next_free[NB-1:0];
    en_wdata   = '0;
    en_raddr   = c_step;
    fin        = 1'b0;
    fin_full   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_STEP;
      end
      ST_STEP: begin
        if (is_lookup) begin
          if (c_step == '0) fin = 1'b1;
          else state_next = ST_LOAD;
        end else if (plen == 8'd0 || end_even) begin
          state_next = ST_PUT;
        end else if (c_step != '0) begin
          state_next = ST_LOAD;
        end else if (pool_full) begin
          fin_full = 1'b1;
        end else begin
          // new path node: empty links, no entry
          lk_we      = 1'b1;
          en_we      = 1'b1;
          state_next = ST_WB;
        end
      end
      ST_LOAD: begin
        if (is_lookup && lvl == LAST_LEVEL) fin = 1'b1;
        else state_next = ST_STEP;
      end
      ST_WB: begin
        lk_we      = (node != '0);
        lk_waddr   = node;
        lk_wdata   = row;
        state_next = ST_STEP;
      end
      ST_PUT: begin
        en_raddr = c_put;
        if (c_put != '0) begin
          state_next = ST_CHK;
        end else if (pool_full) begin
          fin_full = 1'b1;
        end else begin
          lk_we      = 1'b1;
          en_we      = 1'b1;
          en_wdata   = '{valid: 1'b1, plen: plen, as_num: as_in};
          state_next = ST_PWB;
        end
      end
      ST_PWB: begin
        lk_we    = (node != '0);
        lk_waddr = node;
        lk_wdata = row;
        if (slot == last_slot) fin = 1'b1;
        else state_next = ST_PUT;
      end
      ST_CHK: begin
        // an existing entry yields only to an equal or longer prefix
        en_we    = replace_ok;
        en_waddr = c_put;
        en_wdata = '{valid: 1'b1, plen: plen, as_num: as_in};
        if (slot == last_slot) fin = 1'b1;
        else state_next = ST_PUT;
      end
      default: state_next = ST_IDLE;
    endcase
    if (fin || fin_full) state_next = ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (lk_we) lk_mem[lk_waddr] <= lk_wdata;
    if (en_we) en_mem[en_waddr] <= en_wdata;
    lk_rd <= lk_mem[lk_raddr];
    en_rd <= en_mem[en_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free   <= (NB+1)'(1);
      root        <= '0;
      done        <= 1'b0;
      match_found <= 1'b0;
      matched_as  <= '0;
      table_full  <= 1'b0;
    end else begin
      done <= fin || fin_full;
      if (fin || fin_full) begin
        match_found <= is_lookup && found_now;
        matched_as  <= is_lookup ? as_now : 32'd0;
        table_full  <= fin_full;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            addr      <= {addr_high, addr_low};
            plen      <= (prefix_len > MAX_PLEN) ? MAX_PLEN : prefix_len;
            as_in     <= as_number;
            is_lookup <= (cmd == CMD_LOOKUP);
            lvl       <= '0;
            node      <= '0;
            row       <= root;
            found     <= 1'b0;
            found_as  <= '0;
          end
        end
        ST_STEP: begin
          if (!is_lookup && plen == 8'd0) begin
            slot      <= 2'd0;
            last_slot <= 2'd3;
          end else if (!is_lookup && end_odd) begin
            slot      <= {pr[1], 1'b0};
            last_slot <= {pr[1], 1'b1};
          end else if (!is_lookup && end_even) begin
            slot      <= pr;
            last_slot <= pr;
          end else if (c_step != '0) begin
            node <= c_step;
          end else if (!is_lookup && !pool_full) begin
            row[pr]   <= next_free[NB-1:0];
            newc      <= next_free[NB-1:0];
            next_free <= next_free + (NB+1)'(1);
          end
        end
        ST_LOAD: begin
          row      <= lk_rd;
          lvl      <= lvl + LEVEL_BITS'(1);
          addr     <= addr << 2;
          found    <= found_now;
          found_as <= as_now;
        end
        ST_WB: begin
          if (node == '0) root <= row;
          node <= newc;
          row  <= '0;
          lvl  <= lvl + LEVEL_BITS'(1);
          addr <= addr << 2;
        end
        ST_PUT: begin
          if (c_put == '0 && !pool_full) begin
            row[slot] <= next_free[NB-1:0];
            next_free <= next_free + (NB+1)'(1);
          end
        end
        ST_PWB: begin
          if (node == '0) root <= row;
          slot <= slot + 2'd1;
        end
        ST_CHK: begin
          slot <= slot + 2'd1;
        end
        default: ;
      endcase
    end
  end

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted start");

  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= (NB+1)'(NODE_COUNT) && next_free != '0)
    else $error("free node pointer out of range");

  a_full_insert_only: assert property (@(posedge clk) disable iff (rst)
    (done && table_full) |-> !match_found)
    else $error("table_full on a lookup result");

endmodule
